// File: design/ikop_pkg.sv
`default_nettype none
package ikop_pkg;

    // Sequencer index width (covers divider steps and up to 64 CORDIC steps)
    localparam int IDX_W = 6;
    // Quotient bits produced by the bit-serial divider
    localparam int DIV_STEPS = 33;
    localparam int SQ_W = 64;
    localparam int DEN_W = 38;
    localparam int REM_W = 39;
    localparam int QUO_W = 33;
    localparam logic [REM_W-1:0] REM_INIT = 39'd50331648; // 6*2^56 >> 33

    // Angle path, signed Q30
    localparam int ANG_W = 36;
    localparam logic signed [ANG_W-1:0] ANGLE_BIAS = 36'sd429496730;
    localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30 = 36'sd6746518852;

    // Cosine/sine path
    localparam int CS_W = 34;
    localparam logic signed [CS_W-1:0] K_Q30 = 34'sd652032874;

    // Rounded arctangents for the first steps; later steps are 2^(30-i)
    localparam logic [29:0] ATAN_LOW [13] = '{
        30'd843314857, 30'd497837830, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775852, 30'd8388438, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144
    };

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCARD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOL = 2'd2;
    localparam logic [30:0] GAIN_RESET = 31'd966367641;
    localparam logic [15:0] DISCARD_RESET = 16'd4096;
    localparam logic [15:0] TOL_RESET = 16'd1;

    localparam int STEP_W = 17;
    localparam int MPASS_W = 3;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQ_RE,
        OP_SQ_IM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ANGLE,
        OP_CORDIC,
        OP_UNFLIP,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ROT_T_SET,
        OP_ROT_T_SUB,
        OP_ROT_U_SET,
        OP_ROT_U_ADD,
        OP_GAIN_RE,
        OP_GAIN_IM,
        OP_RECORD,
        OP_RESULT
    } t_op;

    typedef enum logic [1:0] {A_RE, A_IM, A_T, A_U} t_asel;
    typedef enum logic [1:0] {B_X, B_Y, B_GAIN} t_bsel;

    typedef struct packed {
        t_op              op;
        t_asel            a_sel;
        t_bsel            b_sel;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic signed [ANG_W-1:0] atan_step(input logic [IDX_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        v = '0;
        if (i < IDX_W'(13)) begin
            v = ANG_W'(ATAN_LOW[i[3:0]]);
        end else if (i <= IDX_W'(30)) begin
            v = ANG_W'(36'd1 << (IDX_W'(30) - i));
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// File: design/ikop_if.sv
`default_nettype none
interface ikop_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_re;
    logic signed [31:0] start_im;
    modport source (output valid, output start_re, output start_im, input ready);
    modport sink (input valid, input start_re, input start_im, output ready);
endinterface

interface ikop_out_if;
    logic               valid;
    logic               ready;
    logic               periodic;
    logic signed [31:0] final_re;
    logic signed [31:0] final_im;
    modport source (output valid, output periodic, output final_re, output final_im,
                    input ready);
    modport sink (input valid, input periodic, input final_re, input final_im,
                  output ready);
endinterface

interface ikop_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ikop_pkg::CFG_IDX_W-1:0]       index;
    logic [ikop_pkg::CFG_DATA_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: design/ikop_ctrl.sv
`default_nettype none
module ikop_ctrl #(
    parameter int PERIOD_SPAN  = 16,
    parameter int CORDIC_STEPS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [15:0]        i_discard_steps,
    input  wire ikop_pkg::t_status  i_status,
    output ikop_pkg::t_cmd          o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ_RE, S_SQ_IM, S_DIV_INIT, S_DIV, S_ANGLE, S_CORDIC,
        S_UNFLIP, S_MUL_LO, S_MUL_HI, S_COMMIT, S_RECORD, S_RESULT
    } t_state;

    localparam int LAST_PASS = 5;

    t_state                            r_state, n_state;
    logic [ikop_pkg::IDX_W-1:0]        r_cnt, n_cnt;
    logic [ikop_pkg::MPASS_W-1:0]      r_mul, n_mul;
    logic [ikop_pkg::STEP_W-1:0]       r_steps, n_steps;
    logic [ikop_pkg::STEP_W-1:0]       w_rec_at, w_end_at;

    assign w_rec_at = ikop_pkg::STEP_W'(i_discard_steps) + ikop_pkg::STEP_W'(1);
    assign w_end_at = w_rec_at + ikop_pkg::STEP_W'(PERIOD_SPAN);
    assign o_in_ready = (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mul   = r_mul;
        n_steps = r_steps;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SQ_RE;
                    n_steps = '0;
                end
            end
            S_SQ_RE: n_state = S_SQ_IM;
            S_SQ_IM: n_state = S_DIV_INIT;
            S_DIV_INIT: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                n_cnt = r_cnt + ikop_pkg::IDX_W'(1);
                if (r_cnt == ikop_pkg::IDX_W'(ikop_pkg::DIV_STEPS - 1)) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                n_state = S_CORDIC;
                n_cnt   = '0;
            end
            S_CORDIC: begin
                n_cnt = r_cnt + ikop_pkg::IDX_W'(1);
                if (r_cnt == ikop_pkg::IDX_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_UNFLIP;
                end
            end
            S_UNFLIP: begin
                n_state = S_MUL_LO;
                n_mul   = '0;
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_COMMIT;
            S_COMMIT: begin
                if (r_mul == ikop_pkg::MPASS_W'(LAST_PASS)) begin
                    // one map step finished
                    n_steps = r_steps + ikop_pkg::STEP_W'(1);
                    if (n_steps == w_rec_at) begin
                        n_state = S_RECORD;
                    end else if (n_steps == w_end_at) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SQ_RE;
                    end
                end else begin
                    n_mul   = r_mul + ikop_pkg::MPASS_W'(1);
                    n_state = S_MUL_LO;
                end
            end
            S_RECORD: n_state = S_SQ_RE;
            S_RESULT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command decode
    always_comb begin
        o_cmd.op    = ikop_pkg::OP_NOP;
        o_cmd.idx   = r_cnt;
        o_cmd.a_sel = ikop_pkg::A_RE;
        o_cmd.b_sel = ikop_pkg::B_X;
        case (r_mul)
            3'd0: begin
                o_cmd.a_sel = ikop_pkg::A_RE;
                o_cmd.b_sel = ikop_pkg::B_X;
            end
            3'd1: begin
                o_cmd.a_sel = ikop_pkg::A_IM;
                o_cmd.b_sel = ikop_pkg::B_Y;
            end
            3'd2: begin
                o_cmd.a_sel = ikop_pkg::A_RE;
                o_cmd.b_sel = ikop_pkg::B_Y;
            end
            3'd3: begin
                o_cmd.a_sel = ikop_pkg::A_IM;
                o_cmd.b_sel = ikop_pkg::B_X;
            end
            3'd4: begin
                o_cmd.a_sel = ikop_pkg::A_T;
                o_cmd.b_sel = ikop_pkg::B_GAIN;
            end
            default: begin
                o_cmd.a_sel = ikop_pkg::A_U;
                o_cmd.b_sel = ikop_pkg::B_GAIN;
            end
        endcase
        case (r_state)
            S_IDLE:     if (i_in_valid) o_cmd.op = ikop_pkg::OP_LOAD;
            S_SQ_RE:    o_cmd.op = ikop_pkg::OP_SQ_RE;
            S_SQ_IM:    o_cmd.op = ikop_pkg::OP_SQ_IM;
            S_DIV_INIT: o_cmd.op = ikop_pkg::OP_DIV_INIT;
            S_DIV:      o_cmd.op = ikop_pkg::OP_DIV_STEP;
            S_ANGLE:    o_cmd.op = ikop_pkg::OP_ANGLE;
            S_CORDIC:   o_cmd.op = ikop_pkg::OP_CORDIC;
            S_UNFLIP:   o_cmd.op = ikop_pkg::OP_UNFLIP;
            S_MUL_LO:   o_cmd.op = ikop_pkg::OP_MUL_LO;
            S_MUL_HI:   o_cmd.op = ikop_pkg::OP_MUL_HI;
            S_COMMIT: begin
                case (r_mul)
                    3'd0:    o_cmd.op = ikop_pkg::OP_ROT_T_SET;
                    3'd1:    o_cmd.op = ikop_pkg::OP_ROT_T_SUB;
                    3'd2:    o_cmd.op = ikop_pkg::OP_ROT_U_SET;
                    3'd3:    o_cmd.op = ikop_pkg::OP_ROT_U_ADD;
                    3'd4:    o_cmd.op = ikop_pkg::OP_GAIN_RE;
                    default: o_cmd.op = ikop_pkg::OP_GAIN_IM;
                endcase
            end
            S_RECORD:   o_cmd.op = ikop_pkg::OP_RECORD;
            S_RESULT:   if (i_status.out_free) o_cmd.op = ikop_pkg::OP_RESULT;
            default:    o_cmd.op = ikop_pkg::OP_NOP;
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_mul   <= '0;
            r_steps <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_mul   <= n_mul;
            r_steps <= n_steps;
        end
    end

endmodule
`default_nettype wire

// File: design/ikop_dp.sv
`default_nettype none
module ikop_dp #(
    parameter int POINT_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ikop_pkg::t_cmd     i_cmd,
    input  wire logic [30:0]        i_gain,
    input  wire logic [15:0]        i_tolerance,
    input  wire logic signed [31:0] i_start_re,
    input  wire logic signed [31:0] i_start_im,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_periodic,
    output logic signed [31:0]      o_final_re,
    output logic signed [31:0]      o_final_im,
    output ikop_pkg::t_status       o_status
);

    localparam int PW   = POINT_WIDTH;
    localparam int FRAC = PW - 6;
    localparam int UP   = (FRAC >= 26) ? FRAC - 26 : 0;
    localparam int DN   = (FRAC >= 26) ? 0 : 26 - FRAC;
    localparam int AW   = PW + 4;
    localparam int BW   = ikop_pkg::CS_W;
    localparam int PRW  = AW + BW;
    localparam int FLW  = PRW - 30;
    localparam logic signed [FLW-1:0] ONE_FX = FLW'(1) <<< FRAC;

    // clamp to a signed width given in bits
    function automatic logic signed [63:0] sat_to(input logic signed [63:0] v,
                                                  input int unsigned bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    logic signed [PW-1:0]                r_re, r_im, r_rec_re, r_rec_im;
    logic [ikop_pkg::SQ_W-1:0]           r_sq;
    logic [ikop_pkg::DEN_W-1:0]          r_d;
    logic [ikop_pkg::REM_W-1:0]          r_rem;
    logic [ikop_pkg::QUO_W-1:0]          r_q;
    logic signed [ikop_pkg::ANG_W-1:0]   r_theta;
    logic                                r_flip;
    logic signed [BW-1:0]                r_x, r_y;
    logic signed [PRW-1:0]               r_acc;
    logic signed [AW-1:0]                r_t, r_u;
    logic                                r_out_valid;
    logic                                r_periodic;
    logic signed [31:0]                  r_final_re, r_final_im;

    // magnitude squares, shared squarer
    logic signed [63:0] w_mag_ext, w_mag_abs;
    logic [31:0]        w_mag;
    logic [63:0]        w_sq;
    assign w_mag_ext = 64'((i_cmd.op == ikop_pkg::OP_SQ_IM) ? r_im : r_re);
    assign w_mag_abs = (w_mag_ext < 0) ? -w_mag_ext : w_mag_ext;
    assign w_mag     = 32'((w_mag_abs >> UP) << DN);
    assign w_sq      = 64'(w_mag) * 64'(w_mag);

    // divider step
    logic [ikop_pkg::REM_W-1:0] w_rem2;
    assign w_rem2 = {r_rem[ikop_pkg::REM_W-2:0], 1'b0};

    // angle and range reduction
    logic signed [ikop_pkg::ANG_W-1:0] w_th0, w_th1, w_th2;
    logic                              w_flip;
    always_comb begin
        w_th0  = ikop_pkg::ANGLE_BIAS - $signed(ikop_pkg::ANG_W'(r_q));
        w_th1  = (w_th0 < -ikop_pkg::PI_Q30) ? w_th0 + ikop_pkg::TWO_PI_Q30 : w_th0;
        w_th2  = w_th1;
        w_flip = 1'b0;
        if (w_th1 > ikop_pkg::HALF_PI_Q30) begin
            w_th2  = w_th1 - ikop_pkg::PI_Q30;
            w_flip = 1'b1;
        end else if (w_th1 < -ikop_pkg::HALF_PI_Q30) begin
            w_th2  = w_th1 + ikop_pkg::PI_Q30;
            w_flip = 1'b1;
        end
    end

    // one CORDIC rotation step
    logic signed [BW-1:0]              w_dx, w_dy;
    logic signed [ikop_pkg::ANG_W-1:0] w_atan;
    assign w_dx   = r_y >>> i_cmd.idx;
    assign w_dy   = r_x >>> i_cmd.idx;
    assign w_atan = ikop_pkg::atan_step(i_cmd.idx);

    // multiplier operands, split into two partial products
    logic signed [AW-1:0]   w_a;
    logic signed [BW-1:0]   w_b;
    logic signed [17:0]     w_b_lo;
    logic signed [16:0]     w_b_hi;
    logic signed [AW+17:0]  w_p_lo;
    logic signed [AW+16:0]  w_p_hi;
    logic signed [FLW-1:0]  w_fl, w_gv;
    always_comb begin
        case (i_cmd.a_sel)
            ikop_pkg::A_RE: w_a = AW'(r_re);
            ikop_pkg::A_IM: w_a = AW'(r_im);
            ikop_pkg::A_T:  w_a = r_t;
            ikop_pkg::A_U:  w_a = r_u;
            default:        w_a = r_t;
        endcase
        case (i_cmd.b_sel)
            ikop_pkg::B_X:    w_b = r_x;
            ikop_pkg::B_Y:    w_b = r_y;
            ikop_pkg::B_GAIN: w_b = $signed({3'b000, i_gain});
            default:          w_b = r_x;
        endcase
    end
    assign w_b_lo = $signed({1'b0, w_b[16:0]});
    assign w_b_hi = w_b[BW-1:17];
    assign w_p_lo = w_a * w_b_lo;
    assign w_p_hi = w_a * w_b_hi;
    assign w_fl   = FLW'(r_acc >>> 30);
    assign w_gv   = w_fl + ONE_FX;

    // start point load and result store
    logic signed [63:0] w_ld_re, w_ld_im, w_st_re, w_st_im;
    logic signed [PW:0] w_dre, w_dim, w_are, w_aim;
    assign w_ld_re = (64'(i_start_re) <<< UP) >>> DN;
    assign w_ld_im = (64'(i_start_im) <<< UP) >>> DN;
    assign w_st_re = (64'(r_re) >>> UP) <<< DN;
    assign w_st_im = (64'(r_im) >>> UP) <<< DN;
    assign w_dre   = (PW+1)'(r_re) - (PW+1)'(r_rec_re);
    assign w_dim   = (PW+1)'(r_im) - (PW+1)'(r_rec_im);
    assign w_are   = (w_dre < 0) ? -w_dre : w_dre;
    assign w_aim   = (w_dim < 0) ? -w_dim : w_dim;

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ikop_pkg::OP_LOAD: begin
                r_re <= PW'(sat_to(w_ld_re, PW));
                r_im <= PW'(sat_to(w_ld_im, PW));
            end
            ikop_pkg::OP_SQ_RE: r_sq <= w_sq;
            ikop_pkg::OP_SQ_IM: r_sq <= r_sq + w_sq;
            ikop_pkg::OP_DIV_INIT: begin
                r_d   <= ikop_pkg::DEN_W'(r_sq >> 26) + (ikop_pkg::DEN_W'(1) << 26);
                r_rem <= ikop_pkg::REM_INIT;
                r_q   <= '0;
            end
            ikop_pkg::OP_DIV_STEP: begin
                if (w_rem2 >= ikop_pkg::REM_W'(r_d)) begin
                    r_rem <= w_rem2 - ikop_pkg::REM_W'(r_d);
                    r_q   <= {r_q[ikop_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem2;
                    r_q   <= {r_q[ikop_pkg::QUO_W-2:0], 1'b0};
                end
            end
            ikop_pkg::OP_ANGLE: begin
                r_theta <= w_th2;
                r_flip  <= w_flip;
                r_x     <= ikop_pkg::K_Q30;
                r_y     <= '0;
            end
            ikop_pkg::OP_CORDIC: begin
                if (r_theta >= 0) begin
                    r_x     <= r_x - w_dx;
                    r_y     <= r_y + w_dy;
                    r_theta <= r_theta - w_atan;
                end else begin
                    r_x     <= r_x + w_dx;
                    r_y     <= r_y - w_dy;
                    r_theta <= r_theta + w_atan;
                end
            end
            ikop_pkg::OP_UNFLIP: begin
                if (r_flip) begin
                    r_x <= -r_x;
                    r_y <= -r_y;
                end
            end
            ikop_pkg::OP_MUL_LO:    r_acc <= PRW'(w_p_lo);
            ikop_pkg::OP_MUL_HI:    r_acc <= r_acc + (PRW'(w_p_hi) <<< 17);
            ikop_pkg::OP_ROT_T_SET: r_t <= AW'(w_fl);
            ikop_pkg::OP_ROT_T_SUB: r_t <= r_t - AW'(w_fl);
            ikop_pkg::OP_ROT_U_SET: r_u <= AW'(w_fl);
            ikop_pkg::OP_ROT_U_ADD: r_u <= r_u + AW'(w_fl);
            ikop_pkg::OP_GAIN_RE:   r_re <= PW'(sat_to(64'(w_gv), PW));
            ikop_pkg::OP_GAIN_IM:   r_im <= PW'(sat_to(64'(w_gv), PW));
            ikop_pkg::OP_RECORD: begin
                r_rec_re <= r_re;
                r_rec_im <= r_im;
            end
            ikop_pkg::OP_RESULT: begin
                r_periodic <= (w_are <= (PW+1)'(i_tolerance)) &&
                              (w_aim <= (PW+1)'(i_tolerance));
                r_final_re <= 32'(sat_to(w_st_re, 32));
                r_final_im <= 32'(sat_to(w_st_im, 32));
            end
            default: ;
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == ikop_pkg::OP_RESULT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_periodic  = r_periodic;
    assign o_final_re  = r_final_re;
    assign o_final_im  = r_final_im;

endmodule
`default_nettype wire

// File: design/ikeda_orbit_period_check_core.sv
`default_nettype none
// Channel  Dir  Payload                         Transfer when
// i_in     in   start_re, start_im              valid & ready
// o_out    out  periodic, final_re, final_im    valid & ready
// i_cfg    in   index, data                     valid & ready (ready tied high)
//
// One item at a time. A map step runs a bit-serial divider for 33 quotient bits,
// the CORDIC steps, and six products on a split multiplier, each as a low
// partial product, a high partial product and a commit. An item runs
// discard_steps + 1 + PERIOD_SPAN map steps.
// Synchronous active-low reset; no clearing pass. A held result does not block
// the next item; a finished item waits only if the previous result is not taken.
module ikeda_orbit_period_check_core #(
    parameter int PERIOD_SPAN  = 16,
    parameter int CORDIC_STEPS = 32,
    parameter int POINT_WIDTH  = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ikop_in_if.sink       i_in,
    ikop_out_if.source    o_out,
    ikop_cfg_if.sink      i_cfg
);

    logic [30:0]        r_gain;
    logic [15:0]        r_discard;
    logic [15:0]        r_tol;
    ikop_pkg::t_cmd     w_cmd;
    ikop_pkg::t_status  w_status;
    logic               w_in_ready;

    // configuration registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= ikop_pkg::GAIN_RESET;
            r_discard <= ikop_pkg::DISCARD_RESET;
            r_tol     <= ikop_pkg::TOL_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ikop_pkg::REG_GAIN:    r_gain    <= i_cfg.data[30:0];
                ikop_pkg::REG_DISCARD: r_discard <= i_cfg.data[15:0];
                ikop_pkg::REG_TOL:     r_tol     <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = w_in_ready;

    ikop_ctrl #(
        .PERIOD_SPAN  (PERIOD_SPAN),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in.valid),
        .o_in_ready      (w_in_ready),
        .i_discard_steps (r_discard),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    ikop_dp #(
        .POINT_WIDTH (POINT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_gain      (r_gain),
        .i_tolerance (r_tol),
        .i_start_re  (i_in.start_re),
        .i_start_im  (i_in.start_im),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_periodic  (o_out.periodic),
        .o_final_re  (o_out.final_re),
        .o_final_im  (o_out.final_im),
        .o_status    (w_status)
    );

`ifndef SYNTHESIS
    // an accepted item keeps the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready right after an accepted item");

    // a result appears only from the result command
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.op == ikop_pkg::OP_RESULT))
        else $error("output valid rose without a result command");
`endif

endmodule
`default_nettype wire
